// ===== rtl/psswl_pkg.sv =====
package psswl_pkg;

  // defaults for the top-level parameters
  localparam int SOURCES_DEF = 32;
  localparam int STAMPS_DEF  = 16;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_WINDOW      = 2'd0;
  localparam logic [1:0] REG_START_LIMIT = 2'd1;
  localparam logic [1:0] REG_CLAIM_LIMIT = 2'd2;

  localparam logic [15:0] WINDOW_RST      = 16'd60;
  localparam logic [4:0]  START_LIMIT_RST = 5'd3;
  localparam logic [4:0]  CLAIM_LIMIT_RST = 5'd10;

  typedef struct packed {
    logic [15:0] window_seconds;
    logic [4:0]  start_limit;
    logic [4:0]  claim_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CNT_RD,
    ST_CNT_WT,
    ST_SCAN,
    ST_DECIDE
  } state_e;

endpackage

// ===== rtl/psswl_ram.sv =====
module psswl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/psswl_cfg.sv =====
module psswl_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psswl_pkg::PADDR_W-1:0]       paddr,
  input  logic [psswl_pkg::PDATA_W-1:0]       pwdata,
  output logic [psswl_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  output psswl_pkg::cfg_t                     cfg_o
);
  import psswl_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW:      cfg_d.window_seconds = pwdata[15:0];
        REG_START_LIMIT: cfg_d.start_limit    = pwdata[4:0];
        REG_CLAIM_LIMIT: cfg_d.claim_limit    = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW:      prdata = {16'd0, cfg_q.window_seconds};
      REG_START_LIMIT: prdata = {27'd0, cfg_q.start_limit};
      REG_CLAIM_LIMIT: prdata = {27'd0, cfg_q.claim_limit};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_seconds <= WINDOW_RST;
      cfg_q.start_limit    <= START_LIMIT_RST;
      cfg_q.claim_limit    <= CLAIM_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/psswl_seq.sv =====
module psswl_seq #(
  parameter int SOURCES_PER_BUCKET = psswl_pkg::SOURCES_DEF,
  parameter int STAMPS_PER_SOURCE  = psswl_pkg::STAMPS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psswl_pkg::cfg_t cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            bucket_select_i,
  input  logic [31:0]     source_address_i,
  input  logic [31:0]     now_seconds_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            allowed_o,
  output logic            table_full_o,
  output logic [4:0]      recent_count_o
);
  import psswl_pkg::*;

  localparam int S   = SOURCES_PER_BUCKET;
  localparam int P   = STAMPS_PER_SOURCE;
  localparam int EW  = $clog2(2 * S);
  localparam int IW  = $clog2(S + 1);
  localparam int CW  = $clog2(P + 1);
  localparam int SAW = $clog2(2 * S * P);

  state_e          state_q, state_d;
  logic            bucket_q, bucket_d;
  logic [31:0]     src_q, src_d;
  logic [31:0]     now_q, now_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            chk_q, chk_d;
  logic [EW-1:0]   entry_q, entry_d;
  logic [CW-1:0]   j_q, j_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   kept_q, kept_d;
  logic            full_q, full_d;
  logic [IW-1:0]   fill_q [2];
  logic [IW-1:0]   fill_d [2];
  logic            out_valid_q, out_valid_d;
  logic            out_allowed_q, out_allowed_d;
  logic            out_full_q, out_full_d;
  logic [4:0]      out_count_q, out_count_d;

  logic [EW-1:0]   base;
  logic [IW-1:0]   fill_cur;
  logic [SAW-1:0]  stamp_base;
  logic [4:0]      limit;
  logic            keep;
  logic            allow;

  // source memory
  logic            src_we;
  logic [EW-1:0]   src_waddr, src_raddr;
  logic [31:0]     src_rdata;
  // count memory
  logic            cnt_we;
  logic [CW-1:0]   cnt_wdata, cnt_rdata;
  // stamp memory
  logic            stamp_we;
  logic [31:0]     stamp_wdata, stamp_rdata;
  logic [SAW-1:0]  stamp_waddr, stamp_raddr;

  assign base       = bucket_q ? EW'(S) : '0;
  assign fill_cur   = fill_q[bucket_q];
  assign stamp_base = SAW'(entry_q) * SAW'(P);
  assign limit      = bucket_q ? cfg_i.claim_limit : cfg_i.start_limit;

  assign src_raddr   = base + EW'(idx_q);
  assign stamp_raddr = stamp_base + SAW'(j_q);
  assign stamp_waddr = stamp_base + SAW'(kept_q);

  // a stamp stays while stamp + window >= now
  assign keep = ({1'b0, stamp_rdata} + {17'd0, cfg_i.window_seconds}) >= {1'b0, now_q};
  assign allow = (32'(kept_q) < 32'(limit)) && (32'(kept_q) < P);

  always_comb begin
    state_d       = state_q;
    bucket_d      = bucket_q;
    src_d         = src_q;
    now_d         = now_q;
    idx_d         = idx_q;
    chk_d         = chk_q;
    entry_d       = entry_q;
    j_d           = j_q;
    n_d           = n_q;
    kept_d        = kept_q;
    full_d        = full_q;
    fill_d        = fill_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_allowed_d = out_allowed_q;
    out_full_d    = out_full_q;
    out_count_d   = out_count_q;
    in_ready_o    = 1'b0;
    src_we        = 1'b0;
    src_waddr     = entry_q;
    cnt_we        = 1'b0;
    cnt_wdata     = kept_q;
    stamp_we      = 1'b0;
    stamp_wdata   = now_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          bucket_d = bucket_select_i;
          src_d    = source_address_i;
          now_d    = now_seconds_i;
          idx_d    = '0;
          chk_d    = 1'b0;
          full_d   = 1'b0;
          state_d  = ST_SEARCH;
        end
      end
      // one entry read per cycle, compared in the cycle after its read
      ST_SEARCH: begin
        if (chk_q && src_rdata == src_q) begin
          entry_d = base + EW'(idx_q - 1'b1);
          state_d = ST_CNT_RD;
        end else if (idx_q == fill_cur) begin
          if (fill_cur == IW'(S)) begin
            full_d  = 1'b1;
          end else begin
            // entries fill from the bottom and are never freed
            entry_d          = base + EW'(fill_cur);
            src_we           = 1'b1;
            src_waddr        = base + EW'(fill_cur);
            fill_d[bucket_q] = fill_cur + 1'b1;
            kept_d           = '0;
          end
          state_d = ST_DECIDE;
        end else begin
          chk_d = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      ST_CNT_RD: begin
        state_d = ST_CNT_WT;
      end
      ST_CNT_WT: begin
        n_d     = (32'(cnt_rdata) > P) ? CW'(P) : cnt_rdata;
        j_d     = '0;
        chk_d   = 1'b0;
        kept_d  = '0;
        state_d = ST_SCAN;
      end
      // compact kept stamps in place; writes never pass the read pointer
      ST_SCAN: begin
        if (chk_q && keep) begin
          stamp_we    = 1'b1;
          stamp_wdata = stamp_rdata;
          kept_d      = kept_q + 1'b1;
        end
        if (j_q == n_q) begin
          chk_d   = 1'b0;
          state_d = ST_DECIDE;
        end else begin
          chk_d = 1'b1;
          j_d   = j_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (full_q) begin
            out_allowed_d = 1'b0;
            out_full_d    = 1'b1;
            out_count_d   = '0;
          end else begin
            out_allowed_d = allow;
            out_full_d    = 1'b0;
            out_count_d   = 5'(32'(kept_q));
            cnt_we        = 1'b1;
            cnt_wdata     = allow ? kept_q + 1'b1 : kept_q;
            stamp_we      = allow;
            stamp_wdata   = now_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_q       <= 1'b0;
      full_q      <= 1'b0;
      fill_q[0]   <= '0;
      fill_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      full_q      <= full_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bucket_q      <= bucket_d;
    src_q         <= src_d;
    now_q         <= now_d;
    idx_q         <= idx_d;
    entry_q       <= entry_d;
    j_q           <= j_d;
    n_q           <= n_d;
    kept_q        <= kept_d;
    out_allowed_q <= out_allowed_d;
    out_full_q    <= out_full_d;
    out_count_q   <= out_count_d;
  end

  psswl_ram #(
    .WIDTH (32),
    .DEPTH (2 * S)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (src_q),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  psswl_ram #(
    .WIDTH (CW),
    .DEPTH (2 * S)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (entry_q),
    .wdata_i (cnt_wdata),
    .raddr_i (entry_q),
    .rdata_o (cnt_rdata)
  );

  psswl_ram #(
    .WIDTH (32),
    .DEPTH (2 * S * P)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (stamp_waddr),
    .wdata_i (stamp_wdata),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign allowed_o      = out_allowed_q;
  assign table_full_o   = out_full_q;
  assign recent_count_o = out_count_q;

endmodule

// ===== rtl/per_source_sliding_window_limiter_top.sv =====
// Per-source sliding-log rate limiter with a start bucket and a claim bucket. Each
// request transfer carries the bucket in tuser and the source address and time in
// tdata; the block looks the source up in that bucket (or takes the next free entry),
// drops stamps older than now minus window_seconds, and allows and stamps the request
// while the kept count is below both the bucket's limit and STAMPS_PER_SOURCE. A bucket
// with all entries in use denies new sources with table_full set. A request for a known
// source walks the source memory and then its stamps in the stamp memory one word per
// cycle, each through a single read port; a new or refused source walks only the source
// memory. A new request is taken once the last one has left its result in the output
// register, and that result may still wait there. Entries fill from the bottom of each
// bucket and are tracked by a fill count, so no clearing pass follows reset. Registers:
// window_seconds at 0x0, start_limit at 0x4, claim_limit at 0x8.
module per_source_sliding_window_limiter_top #(
  parameter int SOURCES_PER_BUCKET = psswl_pkg::SOURCES_DEF,
  parameter int STAMPS_PER_SOURCE  = psswl_pkg::STAMPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psswl_pkg::PADDR_W-1:0] paddr,
  input  logic [psswl_pkg::PDATA_W-1:0] pwdata,
  output logic [psswl_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  // requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // source_address, now_seconds
  input  logic                          s_axis_tuser,  // bucket_select
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata   // allowed, table_full, recent_count
);
  import psswl_pkg::*;

  cfg_t       cfg;
  logic       allowed;
  logic       table_full;
  logic [4:0] recent_count;

  psswl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  psswl_seq #(
    .SOURCES_PER_BUCKET (SOURCES_PER_BUCKET),
    .STAMPS_PER_SOURCE  (STAMPS_PER_SOURCE)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .bucket_select_i  (s_axis_tuser),
    .source_address_i (s_axis_tdata[31:0]),
    .now_seconds_i    (s_axis_tdata[63:32]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .allowed_o        (allowed),
    .table_full_o     (table_full),
    .recent_count_o   (recent_count)
  );

  assign m_axis_tdata = {1'b0, recent_count, table_full, allowed};

endmodule

// ===== bench/per_source_sliding_window_limiter_top_tb.sv =====
`timescale 1ns / 100ps

module per_source_sliding_window_limiter_top_tb;
  import psswl_pkg::*;

  localparam int SRC_N   = SOURCES_DEF;
  localparam int STAMP_N = STAMPS_DEF;
  localparam int ENT_N   = 2 * SRC_N;
  localparam int SETTLE  = SRC_N + STAMP_N + 10;

  typedef struct packed {
    bit        bucket;
    bit [31:0] src;
    bit [31:0] now;
  } request_t;

  typedef struct packed {
    bit       allowed;
    bit       table_full;
    bit [4:0] recent_count;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;  // source_address, now_seconds
  logic              s_axis_tuser = 1'b0;  // bucket_select
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;  // allowed, table_full, recent_count

  per_source_sliding_window_limiter_top #(
    .SOURCES_PER_BUCKET(SRC_N),
    .STAMPS_PER_SOURCE (STAMP_N)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // limiter state as the testbench sees it
  bit [15:0] cfg_window = WINDOW_RST;
  bit [4:0]  cfg_start  = START_LIMIT_RST;
  bit [4:0]  cfg_claim  = CLAIM_LIMIT_RST;
  bit        ent_used  [ENT_N];
  bit [31:0] ent_src   [ENT_N];
  int        ent_cnt   [ENT_N];
  bit [31:0] ent_stamp [ENT_N][STAMP_N];

  request_t  pending_q[$];
  verdict_t  verdict_q[$];
  int        sent_cnt, taken_cnt, fail_cnt;
  int        allowed_cnt, limited_cnt, full_cnt;
  bit        req_fired;
  int        sender_idle_pct, recv_stall_pct;
  int        hold_token, hold_seen, hold_len, hold_left;
  bit [31:0] clock_now;
  bit [31:0] src_pool[48];

  function automatic verdict_t judge_request(bit bucket, bit [31:0] src, bit [31:0] now);
    verdict_t v;
    int       i, e, hit, free, slot, kept;
    bit [4:0] lim;
    hit  = -1;
    free = -1;
    for (i = 0; i < SRC_N; i++) begin
      e = int'(bucket) * SRC_N + i;
      if (ent_used[e]) begin
        if (ent_src[e] == src && hit < 0) hit = e;
      end else if (free < 0) begin
        free = e;
      end
    end
    if (hit >= 0) begin
      slot = hit;
    end else if (free >= 0) begin
      slot = free;
      ent_used[slot] = 1'b1;
      ent_src[slot]  = src;
      ent_cnt[slot]  = 0;
    end else begin
      slot = -1;
    end
    v = '0;
    if (slot < 0) begin
      v.table_full = 1'b1;
      return v;
    end
    // drop stale stamps, keeping the rest in order
    kept = 0;
    for (i = 0; i < ent_cnt[slot]; i++) begin
      if ({1'b0, ent_stamp[slot][i]} + {17'b0, cfg_window} >= {1'b0, now}) begin
        ent_stamp[slot][kept] = ent_stamp[slot][i];
        kept++;
      end
    end
    ent_cnt[slot] = kept;
    v.recent_count = kept[4:0];
    lim = bucket ? cfg_claim : cfg_start;
    if (kept < int'(lim) && kept < STAMP_N) begin
      ent_stamp[slot][kept] = now;
      ent_cnt[slot] = kept + 1;
      v.allowed = 1'b1;
    end
    return v;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    request_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !req_fired) begin
      // hold the offered request
    end else if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
      nxt = pending_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {nxt.now, nxt.src};
      s_axis_tuser  <= nxt.bucket;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // result side ready, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_seen != hold_token) begin
      hold_seen     <= hold_token;
      hold_left     <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on each request transfer, check each result transfer
  always @(posedge clk_i) begin
    verdict_t want, got;
    if (!rst_ni) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.insert(verdict_q.size(),
                         judge_request(s_axis_tuser, s_axis_tdata[31:0],
                                       s_axis_tdata[63:32]));
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[6:2]};
        if (verdict_q.size() == 0) begin
          $error("result with nothing pending: tdata %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (got.allowed != want.allowed) begin
            $error("allowed: expected %0d, got %0d", want.allowed, got.allowed);
            fail_cnt++;
          end
          if (got.table_full != want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
            fail_cnt++;
          end
          if (got.recent_count != want.recent_count) begin
            $error("recent_count: expected %0d, got %0d", want.recent_count,
                   got.recent_count);
            fail_cnt++;
          end
          if (want.allowed) allowed_cnt++;
          else if (want.table_full) full_cnt++;
          else limited_cnt++;
        end
      end
    end
  end

  task automatic push_req(bit bucket, bit [31:0] src, bit [31:0] now);
    request_t r;
    r.bucket = bucket;
    r.src    = src;
    r.now    = now;
    pending_q.insert(pending_q.size(), r);
    sent_cnt++;
  endtask

  // wait until every request is taken and answered, then let the block settle
  task automatic wait_quiet();
    while (pending_q.size() > 0 || taken_cnt != sent_cnt || verdict_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [15:0] val);
    logic [31:0] stray;
    stray = $urandom();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (idx == REG_WINDOW) ? {stray[31:16], val} : {stray[31:5], val[4:0]};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_WINDOW:      cfg_window = val;
      REG_START_LIMIT: cfg_start  = val[4:0];
      REG_CLAIM_LIMIT: cfg_claim  = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  int ph_win[6], ph_start[6], ph_claim[6], ph_sidle[6], ph_rstall[6], ph_items[6];

  initial begin
    int        ph, k, r;
    bit [31:0] src;
    bit        bkt;
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < 48; k++) src_pool[k] = $urandom();
    ph_win    = '{1, 65535, 0, 5, 30, 0};
    ph_start  = '{1, 16, 0, 17, 4, 0};
    ph_claim  = '{16, 1, 31, 8, 0, 0};
    ph_sidle  = '{0, 71, 0, 14, 0, 71};
    ph_rstall = '{0, 0, 71, 14, 0, 71};
    ph_items  = '{200, 200, 200, 200, 150, 250};
    ph_win[5]   = $urandom_range(20, 1);
    ph_start[5] = $urandom_range(16, 1);
    ph_claim[5] = $urandom_range(16, 1);

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: early time, limit reached, stale drop, time going back, extremes
    push_req(1'b0, 32'h0000_0000, 32'd0);
    push_req(1'b0, 32'h0000_0000, 32'd0);
    push_req(1'b0, 32'h0000_0000, 32'd1);
    push_req(1'b0, 32'h0000_0000, 32'd59);
    push_req(1'b0, 32'h0000_0000, 32'd60);
    push_req(1'b0, 32'h0000_0000, 32'd61);
    push_req(1'b0, 32'h0000_0000, 32'd30);
    push_req(1'b0, 32'h0000_0000, 32'd200);
    push_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    push_req(1'b1, 32'hFFFF_FFFF, 32'd0);
    push_req(1'b0, 32'h8000_0001, 32'hFFFF_FFC3);
    push_req(1'b0, 32'h8000_0001, 32'h8000_0000);
    push_req(1'b1, 32'h5555_AAAA, 32'd59);
    push_req(1'b1, 32'h5555_AAAA, 32'd120);
    wait_quiet();

    clock_now = 32'd0;
    for (ph = 0; ph < 6; ph++) begin
      apb_write(REG_WINDOW, ph_win[ph][15:0]);
      apb_write(REG_START_LIMIT, ph_start[ph][15:0]);
      apb_write(REG_CLAIM_LIMIT, ph_claim[ph][15:0]);
      sender_idle_pct = ph_sidle[ph];
      recv_stall_pct  = ph_rstall[ph];
      if (ph == 4) begin
        // result side goes quiet while requests keep coming
        hold_len = 400;
        hold_token++;
      end
      for (k = 0; k < ph_items[ph]; k++) begin
        r = $urandom_range(99);
        if (r < 35) ;
        else if (r < 75) clock_now += $urandom_range(3, 1);
        else if (r < 93) clock_now += $urandom_range(int'(cfg_window) * 3 / 2 + 1, 0);
        else if (r < 98) clock_now -= $urandom_range(50, 1);
        else clock_now = $urandom();
        r = $urandom_range(99);
        if (r < 3) src = $urandom();
        else if (r < 85) src = src_pool[$urandom_range(19)];
        else src = src_pool[$urandom_range(47)];
        bkt = $urandom_range(1);
        push_req(bkt, src, clock_now);
      end
      wait_quiet();
    end

    $display("%0d requests through seven settings: %0d allowed, %0d over limit,",
             sent_cnt, allowed_cnt, limited_cnt);
    $display("%0d refused with the source table full", full_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psswl_pkg.sv
rtl/psswl_ram.sv
rtl/psswl_cfg.sv
rtl/psswl_seq.sv
rtl/per_source_sliding_window_limiter_top.sv
bench/per_source_sliding_window_limiter_top_tb.sv
